@@ design/gffe_pkg.sv @@
package gffe_pkg;

  localparam int POS_W   = 28;
  localparam int SQ_W    = 56;
  localparam int MA_W    = 34;
  localparam int PROD_W  = 62;
  localparam int DIV_W   = 50;
  localparam int DEN_W   = 16;
  localparam int SUM_W   = 52;
  localparam int CNT_W   = 6;
  localparam int SQ_ITER = 28;

  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_WHIRL = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic [15:0]        inner_radius;
    logic [15:0]        outer_radius;
    logic signed [31:0] inner_radial;
    logic signed [31:0] outer_radial;
    logic signed [31:0] inner_tangential;
    logic signed [31:0] outer_tangential;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] out_force_x;
    logic signed [31:0] out_force_y;
  } out_res_t;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
  } node_t;

  typedef enum logic [5:0] {
    ST_CLEAR, ST_IDLE, ST_FILL, ST_DIV, ST_SQRT,
    ST_W_MX, ST_W_MY, ST_W_SQX, ST_W_SQY, ST_W_SUM, ST_W_CHK,
    ST_W_RAD, ST_W_TAN0, ST_W_TAN1, ST_W_TAN2,
    ST_W_XA, ST_W_XB, ST_W_XC, ST_W_YA, ST_W_YB, ST_W_YC, ST_W_WR,
    ST_Q_DY, ST_Q_IY, ST_Q_N, ST_Q_N1, ST_Q_N2, ST_Q_N3, ST_Q_N4,
    ST_Q_N5, ST_Q_N6, ST_Q_N7, ST_Q_SY, ST_Q_OUT
  } state_t;

endpackage

@@ design/grid_force_field_engine.sv @@
// Channel  | Ports                          | Handshake
// ---------+--------------------------------+------------------------------
// request  | start, busy, in_req            | taken when start && !busy
// result   | out_strobe, out_res            | one cycle, no backpressure
// config   | cfg_valid, cfg_ready, cfg_grid_step | taken when valid && ready
//
// After reset the grid is cleared one node a cycle; the block is busy until it is done.
// Set: one memory write per node.
// Whirl: one square root per node, and inside the ring up to four divides on the
// bit-serial divider (two when the radii are equal, none outside the ring).
// Query: four divides and four square roots.
// Reset is synchronous, active low; the result side cannot stall.
module grid_force_field_engine #(
  parameter int GRID_X = 64,
  parameter int GRID_Y = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  gffe_pkg::in_req_t   in_req,
  output logic                out_strobe,
  output gffe_pkg::out_res_t  out_res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_grid_step
);

  localparam int DEPTH = GRID_X * GRID_Y;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(GRID_X);
  localparam int YW    = $clog2(GRID_Y);

  gffe_pkg::node_t mem [DEPTH];
  gffe_pkg::node_t rd_r;

  gffe_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [XW-1:0] i_r, i_nxt, ix_r, ix_nxt;
  logic [YW-1:0] j_r, j_nxt, iy_r, iy_nxt;
  logic [1:0]    k_r, k_nxt;
  logic [15:0]   step_r;
  logic          out_strobe_r, out_strobe_nxt;
  gffe_pkg::out_res_t out_res_r, out_res_nxt;
  gffe_pkg::in_req_t  req_r, req_nxt;

  logic signed [gffe_pkg::MA_W-1:0]   mul_a;
  logic signed [gffe_pkg::POS_W-1:0]  mul_b;
  logic signed [gffe_pkg::PROD_W-1:0] prod_r, t1_r, t1_nxt;
  logic signed [gffe_pkg::POS_W-1:0]  dx_r, dx_nxt, dy_r, dy_nxt;
  logic [gffe_pkg::SQ_W-1:0]          sq_r, sq_nxt;
  logic signed [31:0]                 rad_r, rad_nxt, tan_r, tan_nxt;
  logic signed [gffe_pkg::SUM_W-1:0]  sx_r, sx_nxt, sumx_r, sumx_nxt, sumy_r, sumy_nxt;
  logic [15:0]                        c_r, c_nxt;

  logic                              div_go;
  logic signed [63:0]                div_n, div_mag;
  logic [gffe_pkg::DEN_W-1:0]        div_d;
  logic [gffe_pkg::DIV_W-1:0]        dnum_r, dnum_nxt;
  logic [gffe_pkg::DEN_W-1:0]        drem_r, drem_nxt, dden_r, dden_nxt;
  logic                              dneg_r, dneg_nxt;
  logic [gffe_pkg::DEN_W:0]          dtry;
  logic signed [gffe_pkg::SUM_W-1:0] div_q;
  logic [gffe_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;

  logic                       sq_go;
  logic [gffe_pkg::SQ_W-1:0]  sq_val;
  logic [gffe_pkg::SQ_W-1:0]  sv_r, sv_nxt, sr_r, sr_nxt, sb_r, sb_nxt, s_sum;
  logic [gffe_pkg::POS_W-1:0] root;

  logic            we;
  gffe_pkg::node_t wdata;
  logic [15:0]     step;
  logic [XW-1:0]   nx;
  logic [YW-1:0]   ny;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  assign step       = (step_r == 16'd0) ? 16'd1 : step_r;
  assign busy       = (state_r != gffe_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;
  assign root       = sr_r[gffe_pkg::POS_W-1:0];
  assign nx         = ix_r + XW'(k_r[1]);
  assign ny         = iy_r + YW'(k_r[0]);
  assign div_q      = dneg_r ? -$signed({2'b00, dnum_r}) : $signed({2'b00, dnum_r});
  assign dtry       = {drem_r, dnum_r[gffe_pkg::DIV_W-1]};
  assign s_sum      = sr_r + sb_r;
  assign div_mag    = (div_n < 0) ? -div_n : div_n;

  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    addr_nxt       = addr_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    ix_nxt         = ix_r;
    iy_nxt         = iy_r;
    k_nxt          = k_r;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = out_res_r;
    req_nxt        = req_r;
    t1_nxt         = t1_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    sq_nxt         = sq_r;
    rad_nxt        = rad_r;
    tan_nxt        = tan_r;
    sx_nxt         = sx_r;
    sumx_nxt       = sumx_r;
    sumy_nxt       = sumy_r;
    c_nxt          = c_r;
    dnum_nxt       = dnum_r;
    drem_nxt       = drem_r;
    dden_nxt       = dden_r;
    dneg_nxt       = dneg_r;
    cnt_nxt        = cnt_r;
    sv_nxt         = sv_r;
    sr_nxt         = sr_r;
    sb_nxt         = sb_r;
    mul_a          = '0;
    mul_b          = '0;
    div_go         = 1'b0;
    div_n          = '0;
    div_d          = step;
    sq_go          = 1'b0;
    sq_val         = '0;
    we             = 1'b0;
    wdata          = '0;

    case (state_r)
      gffe_pkg::ST_CLEAR: begin
        we       = 1'b1;
        addr_nxt = addr_r + AW'(1);
        if (addr_r == AW'(DEPTH - 1)) begin
          state_nxt = gffe_pkg::ST_IDLE;
        end
      end
      gffe_pkg::ST_IDLE: begin
        if (start) begin
          req_nxt  = in_req;
          addr_nxt = '0;
          i_nxt    = '0;
          j_nxt    = '0;
          k_nxt    = '0;
          sumx_nxt = '0;
          sumy_nxt = '0;
          case (in_req.opcode)
            gffe_pkg::OP_SET:   state_nxt = gffe_pkg::ST_FILL;
            gffe_pkg::OP_WHIRL: state_nxt = gffe_pkg::ST_W_MX;
            gffe_pkg::OP_QUERY: begin
              div_go  = 1'b1;
              div_n   = 64'(in_req.pos_x);
              ret_nxt = gffe_pkg::ST_Q_DY;
            end
            default: state_nxt = gffe_pkg::ST_IDLE;
          endcase
        end
      end
      gffe_pkg::ST_FILL: begin
        we       = 1'b1;
        wdata.fx = req_r.force_x;
        wdata.fy = req_r.force_y;
        addr_nxt = addr_r + AW'(1);
        if (addr_r == AW'(DEPTH - 1)) begin
          state_nxt = gffe_pkg::ST_IDLE;
        end
      end
      gffe_pkg::ST_DIV: begin
        if (dtry >= {1'b0, dden_r}) begin
          drem_nxt = gffe_pkg::DEN_W'(dtry - {1'b0, dden_r});
          dnum_nxt = {dnum_r[gffe_pkg::DIV_W-2:0], 1'b1};
        end else begin
          drem_nxt = dtry[gffe_pkg::DEN_W-1:0];
          dnum_nxt = {dnum_r[gffe_pkg::DIV_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + gffe_pkg::CNT_W'(1);
        if (cnt_r == gffe_pkg::CNT_W'(gffe_pkg::DIV_W - 1)) begin
          state_nxt = ret_r;
        end
      end
      gffe_pkg::ST_SQRT: begin
        if (sv_r >= s_sum) begin
          sv_nxt = sv_r - s_sum;
          sr_nxt = (sr_r >> 1) + sb_r;
        end else begin
          sr_nxt = sr_r >> 1;
        end
        sb_nxt  = sb_r >> 2;
        cnt_nxt = cnt_r + gffe_pkg::CNT_W'(1);
        if (cnt_r == gffe_pkg::CNT_W'(gffe_pkg::SQ_ITER - 1)) begin
          state_nxt = ret_r;
        end
      end
      // whirl, one node per pass
      gffe_pkg::ST_W_MX: begin
        mul_a     = gffe_pkg::MA_W'(step);
        mul_b     = gffe_pkg::POS_W'(i_r);
        state_nxt = gffe_pkg::ST_W_MY;
      end
      gffe_pkg::ST_W_MY: begin
        dx_nxt    = prod_r[gffe_pkg::POS_W-1:0] - gffe_pkg::POS_W'(req_r.pos_x);
        mul_a     = gffe_pkg::MA_W'(step);
        mul_b     = gffe_pkg::POS_W'(j_r);
        state_nxt = gffe_pkg::ST_W_SQX;
      end
      gffe_pkg::ST_W_SQX: begin
        dy_nxt    = prod_r[gffe_pkg::POS_W-1:0] - gffe_pkg::POS_W'(req_r.pos_y);
        mul_a     = gffe_pkg::MA_W'(dx_r);
        mul_b     = dx_r;
        state_nxt = gffe_pkg::ST_W_SQY;
      end
      gffe_pkg::ST_W_SQY: begin
        sq_nxt    = prod_r[gffe_pkg::SQ_W-1:0];
        mul_a     = gffe_pkg::MA_W'(dy_r);
        mul_b     = dy_r;
        state_nxt = gffe_pkg::ST_W_SUM;
      end
      gffe_pkg::ST_W_SUM: begin
        sq_go   = 1'b1;
        sq_val  = sq_r + prod_r[gffe_pkg::SQ_W-1:0];
        ret_nxt = gffe_pkg::ST_W_CHK;
      end
      gffe_pkg::ST_W_CHK: begin
        if (root > gffe_pkg::POS_W'(req_r.outer_radius) ||
            root < gffe_pkg::POS_W'(req_r.inner_radius) || root == '0) begin
          state_nxt = gffe_pkg::ST_W_WR;
          sx_nxt    = '0;
          dneg_nxt  = 1'b0;
          dnum_nxt  = '0;
        end else if (req_r.inner_radius == req_r.outer_radius) begin
          rad_nxt   = req_r.inner_radial;
          tan_nxt   = req_r.inner_tangential;
          state_nxt = gffe_pkg::ST_W_XA;
        end else begin
          mul_a     = gffe_pkg::MA_W'(req_r.outer_radial) - gffe_pkg::MA_W'(req_r.inner_radial);
          mul_b     = root - gffe_pkg::POS_W'(req_r.inner_radius);
          state_nxt = gffe_pkg::ST_W_RAD;
        end
      end
      gffe_pkg::ST_W_RAD: begin
        div_go  = 1'b1;
        div_n   = 64'(prod_r);
        div_d   = req_r.outer_radius - req_r.inner_radius;
        ret_nxt = gffe_pkg::ST_W_TAN0;
      end
      gffe_pkg::ST_W_TAN0: begin
        rad_nxt   = 32'(gffe_pkg::SUM_W'(req_r.inner_radial) + div_q);
        mul_a     = gffe_pkg::MA_W'(req_r.outer_tangential)
                    - gffe_pkg::MA_W'(req_r.inner_tangential);
        mul_b     = root - gffe_pkg::POS_W'(req_r.inner_radius);
        state_nxt = gffe_pkg::ST_W_TAN1;
      end
      gffe_pkg::ST_W_TAN1: begin
        div_go  = 1'b1;
        div_n   = 64'(prod_r);
        div_d   = req_r.outer_radius - req_r.inner_radius;
        ret_nxt = gffe_pkg::ST_W_TAN2;
      end
      gffe_pkg::ST_W_TAN2: begin
        tan_nxt   = 32'(gffe_pkg::SUM_W'(req_r.inner_tangential) + div_q);
        state_nxt = gffe_pkg::ST_W_XA;
      end
      gffe_pkg::ST_W_XA: begin
        mul_a     = gffe_pkg::MA_W'(tan_r);
        mul_b     = dy_r;
        state_nxt = gffe_pkg::ST_W_XB;
      end
      gffe_pkg::ST_W_XB: begin
        t1_nxt    = prod_r;
        mul_a     = gffe_pkg::MA_W'(rad_r);
        mul_b     = dx_r;
        state_nxt = gffe_pkg::ST_W_XC;
      end
      gffe_pkg::ST_W_XC: begin
        div_go  = 1'b1;
        div_n   = 64'(t1_r - prod_r);
        div_d   = root[gffe_pkg::DEN_W-1:0];
        ret_nxt = gffe_pkg::ST_W_YA;
      end
      gffe_pkg::ST_W_YA: begin
        sx_nxt    = div_q;
        mul_a     = gffe_pkg::MA_W'(tan_r);
        mul_b     = dx_r;
        state_nxt = gffe_pkg::ST_W_YB;
      end
      gffe_pkg::ST_W_YB: begin
        t1_nxt    = prod_r;
        mul_a     = gffe_pkg::MA_W'(rad_r);
        mul_b     = dy_r;
        state_nxt = gffe_pkg::ST_W_YC;
      end
      gffe_pkg::ST_W_YC: begin
        div_go  = 1'b1;
        div_n   = 64'(-t1_r - prod_r);
        div_d   = root[gffe_pkg::DEN_W-1:0];
        ret_nxt = gffe_pkg::ST_W_WR;
      end
      gffe_pkg::ST_W_WR: begin
        we       = 1'b1;
        wdata.fx = sat32(64'(rd_r.fx) + 64'(sx_r));
        wdata.fy = sat32(64'(rd_r.fy) + 64'(div_q));
        if (addr_r == AW'(DEPTH - 1)) begin
          state_nxt = gffe_pkg::ST_IDLE;
        end else begin
          addr_nxt  = addr_r + AW'(1);
          state_nxt = gffe_pkg::ST_W_MX;
          if (j_r == YW'(GRID_Y - 1)) begin
            j_nxt = '0;
            i_nxt = i_r + XW'(1);
          end else begin
            j_nxt = j_r + YW'(1);
          end
        end
      end
      // query, four corner nodes
      gffe_pkg::ST_Q_DY: begin
        ix_nxt  = (div_q > gffe_pkg::SUM_W'(GRID_X - 2)) ? XW'(GRID_X - 2)
                                                        : div_q[XW-1:0];
        div_go  = 1'b1;
        div_n   = 64'(req_r.pos_y);
        ret_nxt = gffe_pkg::ST_Q_IY;
      end
      gffe_pkg::ST_Q_IY: begin
        iy_nxt    = (div_q > gffe_pkg::SUM_W'(GRID_Y - 2)) ? YW'(GRID_Y - 2)
                                                          : div_q[YW-1:0];
        state_nxt = gffe_pkg::ST_Q_N;
      end
      gffe_pkg::ST_Q_N: begin
        addr_nxt  = AW'(AW'(nx) * AW'(GRID_Y) + AW'(ny));
        mul_a     = gffe_pkg::MA_W'(step);
        mul_b     = gffe_pkg::POS_W'(nx);
        state_nxt = gffe_pkg::ST_Q_N1;
      end
      gffe_pkg::ST_Q_N1: begin
        dx_nxt    = prod_r[gffe_pkg::POS_W-1:0] - gffe_pkg::POS_W'(req_r.pos_x);
        mul_a     = gffe_pkg::MA_W'(step);
        mul_b     = gffe_pkg::POS_W'(ny);
        state_nxt = gffe_pkg::ST_Q_N2;
      end
      gffe_pkg::ST_Q_N2: begin
        dy_nxt    = prod_r[gffe_pkg::POS_W-1:0] - gffe_pkg::POS_W'(req_r.pos_y);
        mul_a     = gffe_pkg::MA_W'(dx_r);
        mul_b     = dx_r;
        state_nxt = gffe_pkg::ST_Q_N3;
      end
      gffe_pkg::ST_Q_N3: begin
        sq_nxt    = prod_r[gffe_pkg::SQ_W-1:0];
        mul_a     = gffe_pkg::MA_W'(dy_r);
        mul_b     = dy_r;
        state_nxt = gffe_pkg::ST_Q_N4;
      end
      gffe_pkg::ST_Q_N4: begin
        sq_go   = 1'b1;
        sq_val  = sq_r + prod_r[gffe_pkg::SQ_W-1:0];
        ret_nxt = gffe_pkg::ST_Q_N5;
      end
      gffe_pkg::ST_Q_N5: begin
        c_nxt     = (root >= gffe_pkg::POS_W'(step)) ? 16'd0 : step - root[15:0];
        state_nxt = gffe_pkg::ST_Q_N6;
      end
      gffe_pkg::ST_Q_N6: begin
        mul_a     = gffe_pkg::MA_W'(rd_r.fx);
        mul_b     = gffe_pkg::POS_W'(c_r);
        state_nxt = gffe_pkg::ST_Q_N7;
      end
      gffe_pkg::ST_Q_N7: begin
        sumx_nxt  = sumx_r + gffe_pkg::SUM_W'(prod_r);
        mul_a     = gffe_pkg::MA_W'(rd_r.fy);
        mul_b     = gffe_pkg::POS_W'(c_r);
        state_nxt = gffe_pkg::ST_Q_SY;
      end
      gffe_pkg::ST_Q_SY: begin
        sumy_nxt = sumy_r + gffe_pkg::SUM_W'(prod_r);
        if (k_r == 2'd3) begin
          div_go  = 1'b1;
          div_n   = 64'(sumx_r);
          ret_nxt = gffe_pkg::ST_Q_OUT;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = gffe_pkg::ST_Q_N;
        end
      end
      gffe_pkg::ST_Q_OUT: begin
        if (k_r == 2'd3) begin
          out_res_nxt.out_force_x = sat32(64'(div_q));
          k_nxt   = 2'd0;
          div_go  = 1'b1;
          div_n   = 64'(sumy_r);
          ret_nxt = gffe_pkg::ST_Q_OUT;
        end else begin
          out_res_nxt.out_force_y = sat32(64'(div_q));
          out_strobe_nxt          = 1'b1;
          state_nxt               = gffe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gffe_pkg::ST_IDLE;
    endcase

    if (div_go) begin
      dnum_nxt  = div_mag[gffe_pkg::DIV_W-1:0];
      dneg_nxt  = div_n[63];
      dden_nxt  = div_d;
      drem_nxt  = '0;
      cnt_nxt   = '0;
      state_nxt = gffe_pkg::ST_DIV;
    end
    if (sq_go) begin
      sv_nxt    = sq_val;
      sr_nxt    = '0;
      sb_nxt    = gffe_pkg::SQ_W'(1) << (2 * (gffe_pkg::SQ_ITER - 1));
      cnt_nxt   = '0;
      state_nxt = gffe_pkg::ST_SQRT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gffe_pkg::ST_CLEAR;
      ret_r        <= gffe_pkg::ST_IDLE;
      addr_r       <= '0;
      i_r          <= '0;
      j_r          <= '0;
      k_r          <= '0;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
      step_r       <= 16'd64;
    end else begin
      state_r      <= state_nxt;
      ret_r        <= ret_nxt;
      addr_r       <= addr_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      k_r          <= k_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        step_r <= cfg_grid_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r    <= mul_a * mul_b;
    req_r     <= req_nxt;
    out_res_r <= out_res_nxt;
    ix_r      <= ix_nxt;
    iy_r      <= iy_nxt;
    t1_r      <= t1_nxt;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    sq_r      <= sq_nxt;
    rad_r     <= rad_nxt;
    tan_r     <= tan_nxt;
    sx_r      <= sx_nxt;
    sumx_r    <= sumx_nxt;
    sumy_r    <= sumy_nxt;
    c_r       <= c_nxt;
    dnum_r    <= dnum_nxt;
    drem_r    <= drem_nxt;
    dden_r    <= dden_nxt;
    dneg_r    <= dneg_nxt;
    sv_r      <= sv_nxt;
    sr_r      <= sr_nxt;
    sb_r      <= sb_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr_r] <= wdata;
    end
    rd_r <= mem[addr_r];
  end

endmodule

@@ design/gffe_chk.sv @@
module gffe_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input gffe_pkg::in_req_t  in_req,
  input logic               out_strobe,
  input gffe_pkg::out_res_t out_res,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [15:0]        cfg_grid_step
);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while still busy");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without a request in work");

  a_busy_on_request: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.opcode != gffe_pkg::OP_NOP) |=> busy)
    else $error("request taken but block not busy");

endmodule

bind grid_force_field_engine gffe_chk u_gffe_chk (.*);

@@ verif/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GX = 64;
  localparam int GY = 64;
  localparam int STALL_LIMIT = 5000000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  gffe_pkg::in_req_t  in_req;
  logic               out_strobe;
  gffe_pkg::out_res_t out_res;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [15:0]        cfg_grid_step;

  grid_force_field_engine #(.GRID_X(GX), .GRID_Y(GY)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_strobe(out_strobe), .out_res(out_res), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_grid_step(cfg_grid_step)
  );

  gffe_pkg::in_req_t  request_q[$];
  gffe_pkg::out_res_t force_q[$];
  int       grid_fx[GX][GY];
  int       grid_fy[GX][GY];
  int       step_reg;
  int       idle_pct;
  int       errors;
  int       stall_cycles = 0;
  int       whirls_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint distance(longint dx, longint dy);
    longint unsigned ax = dx < 0 ? -dx : dx;
    longint unsigned ay = dy < 0 ? -dy : dy;
    return longint'(root_floor(ax * ax + ay * ay));
  endfunction

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic apply_whirl(gffe_pkg::in_req_t r);
    longint st = step_reg == 0 ? 1 : step_reg;
    longint rin = r.inner_radius;
    longint rout = r.outer_radius;
    longint span = rout - rin;
    longint dx, dy, d, rad, tng, sx, sy;
    for (int i = 0; i < GX; i++) begin
      for (int j = 0; j < GY; j++) begin
        dx = i * st - longint'(r.pos_x);
        dy = j * st - longint'(r.pos_y);
        d = distance(dx, dy);
        if (d > rout || d < rin || d == 0) continue;
        if (span == 0) begin
          rad = r.inner_radial;
          tng = r.inner_tangential;
        end else begin
          rad = longint'(r.inner_radial) + (longint'(r.outer_radial) -
                longint'(r.inner_radial)) * (d - rin) / span;
          tng = longint'(r.inner_tangential) + (longint'(r.outer_tangential) -
                longint'(r.inner_tangential)) * (d - rin) / span;
        end
        sx = (dy * tng - dx * rad) / d;
        sy = (-dx * tng - dy * rad) / d;
        grid_fx[i][j] = clamp32(longint'(grid_fx[i][j]) + sx);
        grid_fy[i][j] = clamp32(longint'(grid_fy[i][j]) + sy);
      end
    end
  endtask

  task automatic predict_force(gffe_pkg::in_req_t r);
    longint st = step_reg == 0 ? 1 : step_reg;
    longint ix = longint'(r.pos_x) / st;
    longint iy = longint'(r.pos_y) / st;
    longint sumx = 0, sumy = 0, c;
    longint nx, ny;
    gffe_pkg::out_res_t res;
    if (ix > GX - 2) ix = GX - 2;
    if (iy > GY - 2) iy = GY - 2;
    for (int k = 0; k < 4; k++) begin
      nx = ix + (k >> 1);
      ny = iy + (k & 1);
      c = st - distance(nx * st - longint'(r.pos_x), ny * st - longint'(r.pos_y));
      if (c < 0) c = 0;
      sumx += c * longint'(grid_fx[nx][ny]);
      sumy += c * longint'(grid_fy[nx][ny]);
    end
    res.out_force_x = clamp32(sumx / st);
    res.out_force_y = clamp32(sumy / st);
    force_q.push_back(res);
  endtask

  task automatic apply_request(gffe_pkg::in_req_t r);
    case (r.opcode)
      gffe_pkg::OP_SET: begin
        for (int i = 0; i < GX; i++)
          for (int j = 0; j < GY; j++) begin
            grid_fx[i][j] = r.force_x;
            grid_fy[i][j] = r.force_y;
          end
      end
      gffe_pkg::OP_WHIRL: apply_whirl(r);
      gffe_pkg::OP_QUERY: predict_force(r);
      default: ;
    endcase
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else begin
      if (start) apply_request(in_req);
      if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_req <= request_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) begin
        if (force_q.size() == 0) begin
          report_mismatch("unexpected result, force_x", out_res.out_force_x, 0);
        end else begin
          if (out_res.out_force_x !== force_q[0].out_force_x)
            report_mismatch("force_x", out_res.out_force_x, force_q[0].out_force_x);
          if (out_res.out_force_y !== force_q[0].out_force_y)
            report_mismatch("force_y", out_res.out_force_y, force_q[0].out_force_y);
          void'(force_q.pop_front());
        end
      end
      if (out_strobe || (start && !busy) || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic write_step(int v);
    cfg_grid_step <= v[15:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    step_reg = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (request_q.size() != 0 || start || busy || force_q.size() != 0);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic gffe_pkg::in_req_t blank_req(logic [1:0] op);
    logic [12*32-1:0] bits;
    gffe_pkg::in_req_t r;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
    r = bits[$bits(gffe_pkg::in_req_t)-1:0];
    r.opcode = op;
    return r;
  endfunction

  function automatic gffe_pkg::in_req_t whirl_req(int cx, int cy, int rin, int rout, int irad,
                                                  int orad, int itan, int otan);
    gffe_pkg::in_req_t r = blank_req(gffe_pkg::OP_WHIRL);
    r.pos_x = cx[15:0];
    r.pos_y = cy[15:0];
    r.inner_radius = rin[15:0];
    r.outer_radius = rout[15:0];
    r.inner_radial = irad;
    r.outer_radial = orad;
    r.inner_tangential = itan;
    r.outer_tangential = otan;
    return r;
  endfunction

  function automatic gffe_pkg::in_req_t query_req(int px, int py);
    gffe_pkg::in_req_t r = blank_req(gffe_pkg::OP_QUERY);
    r.pos_x = px[15:0];
    r.pos_y = py[15:0];
    return r;
  endfunction

  function automatic gffe_pkg::in_req_t set_req(int fx, int fy);
    gffe_pkg::in_req_t r = blank_req(gffe_pkg::OP_SET);
    r.force_x = fx;
    r.force_y = fy;
    return r;
  endfunction

  function automatic gffe_pkg::in_req_t random_req();
    int sel = $urandom_range(999);
    int st = step_reg;
    int span = 63 * st > 65535 ? 65535 : 63 * st;
    int rin, rout;
    if (sel < 10 && whirls_left > 0) begin
      whirls_left--;
      rin = $urandom_range(0, 3 * st);
      rout = rin + $urandom_range(0, 2 * st);
      if (rin > 65535) rin = 65535;
      if (rout > 65535) rout = 65535;
      return whirl_req($urandom_range(0, span), $urandom_range(0, span), rin, rout,
                       $urandom, $urandom, $urandom, $urandom);
    end
    if (sel < 40) return set_req($urandom, $urandom);
    if (sel < 60) return blank_req(gffe_pkg::OP_NOP);
    if (sel < 300) return query_req($urandom_range(0, 65535), $urandom_range(0, 65535));
    return query_req($urandom_range(0, span), $urandom_range(0, span));
  endfunction

  initial begin
    int steps[5] = '{64, 1, 65535, 40, 100};
    int idles[5] = '{0, 59, 0, 23, 59};
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cfg_valid = 1'b0;
    cfg_grid_step = '0;
    errors = 0;
    idle_pct = 0;
    step_reg = 64;
    whirls_left = 3;
    for (int i = 0; i < GX; i++)
      for (int j = 0; j < GY; j++) begin
        grid_fx[i][j] = 0;
        grid_fy[i][j] = 0;
      end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < 5; p++) begin
      drain();
      write_step(steps[p]);
      idle_pct = idles[p];
      if (p == 0) begin
        request_q.push_back(query_req(100, 100));
        request_q.push_back(set_req(32'sh7fffffff, 32'sh80000000));
        request_q.push_back(query_req(0, 0));
        request_q.push_back(query_req(65535, 65535));
        request_q.push_back(query_req(640, 640));
        // ring around a node: centre node gets nothing, sums saturate
        request_q.push_back(whirl_req(640, 640, 0, 200, 32'sh7fffffff, 32'sh80000000,
                                      32'sh80000000, 32'sh7fffffff));
        request_q.push_back(query_req(650, 610));
        request_q.push_back(set_req(32'sh12345, -32'sh5432));
        // equal radii
        request_q.push_back(whirl_req(600, 700, 128, 128, 32'sh10000, 32'sh7000000,
                                      -32'sh30000, 32'sh100));
        request_q.push_back(query_req(600, 580));
        request_q.push_back(query_req(700, 700));
        // inner above outer
        request_q.push_back(whirl_req(640, 640, 65535, 100, 1, 2, 3, 4));
        request_q.push_back(query_req(700, 640));
        // nothing in reach of a far centre
        request_q.push_back(whirl_req(65535, 65535, 32768, 65535, -1, 1, -1, 1));
        request_q.push_back(blank_req(gffe_pkg::OP_NOP));
        request_q.push_back(query_req(4032, 4032));
        request_q.push_back(query_req(4100, 10));
        request_q.push_back(set_req(32'sh80000000, 32'sh7fffffff));
        request_q.push_back(query_req(32, 32));
        request_q.push_back(query_req(0, 65535));
      end
      for (int n = 0; n < 190; n++) request_q.push_back(random_req());
    end

    drain();
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
design/gffe_pkg.sv
design/grid_force_field_engine.sv
design/gffe_chk.sv
verif/tb_top.sv
